// ----- src/mersenne_twister_prng_macros.svh -----
// Assertion macros used by the checker of the generator.
`ifndef MERSENNE_TWISTER_PRNG_MACROS_SVH
`define MERSENNE_TWISTER_PRNG_MACROS_SVH

// Property that is checked only while reset is low.
`define MTP_CHECK(name, clock, reset, prop, msg) \
  name: assert property (@(posedge clock) disable iff (reset) prop) \
    else $error(msg);

// Property that is checked on every edge, reset included.
`define MTP_CHECK_ALWAYS(name, clock, prop, msg) \
  name: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- src/mt_prng_pkg.sv -----
package mt_prng_pkg;

  // Geometry of the generator state.
  localparam int STATE_WORDS       = 624;
  localparam int TWIST_OFFSET      = 397;
  localparam int DEFAULT_MAX_BURST = 64;
  localparam int ADDR_W            = $clog2(STATE_WORDS);
  localparam int POS_W             = $clog2(STATE_WORDS + 2);
  localparam int BURST_W           = 7;
  localparam int WORD_W            = 32;

  // Read position codes above the last word.
  localparam logic [POS_W-1:0] POS_TWIST = POS_W'(STATE_WORDS);
  localparam logic [POS_W-1:0] POS_SEED  = POS_W'(STATE_WORDS + 1);

  // Algorithm constants.
  localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_b0df;
  localparam logic [WORD_W-1:0] UPPER_MASK   = 32'h8000_0000;
  localparam logic [WORD_W-1:0] LOWER_MASK   = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
  localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;
  localparam logic [WORD_W-1:0] SEED_MULT    = 32'd1812433253;
  localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd5489;

  // Output tempering of one state word.
  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] y_in);
    logic [WORD_W-1:0] y;
    y = y_in;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  // One step of the state regeneration.
  function automatic logic [WORD_W-1:0] mix(input logic [WORD_W-1:0] hi_word,
                                            input logic [WORD_W-1:0] lo_word,
                                            input logic [WORD_W-1:0] far_word);
    logic [WORD_W-1:0] y;
    y = (hi_word & UPPER_MASK) | (lo_word & LOWER_MASK);
    return far_word ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : '0);
  endfunction

endpackage

// ----- src/mt_prng_channels.sv -----
// Request channel: one word carries a burst length.
interface mt_req_if import mt_prng_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BURST_W-1:0] burst_length;

  modport source (output valid, output burst_length, input ready);
  modport sink (input valid, input burst_length, output ready);
endinterface

// Result channel: one tempered word with its end-of-burst mark.
interface mt_word_if import mt_prng_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] random_word;
  logic              burst_last;

  modport source (output valid, output random_word, output burst_last, input ready);
  modport sink (input valid, input random_word, input burst_last, output ready);
endinterface

// Seed register write channel.
interface mt_seed_if import mt_prng_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] seed;

  modport source (output valid, output seed, input ready);
  modport sink (input valid, input seed, output ready);
endinterface

// ----- src/mersenne_twister_prng.sv -----
// 32-bit MT19937 generator with a request/result word interface.
// request: one word asks for burst_length words (1 to MAX_BURST, larger values
//   are clipped to MAX_BURST, zero gives nothing). request.ready is high only
//   while no burst is being read out of the state.
// result: one tempered word per cycle outside seeding and regeneration, with
//   burst_last set on the final word. Results pass a two-entry output queue;
//   on a receiver stall, reads stop when it is full and resume at full rate.
// cfg: writes the seed register; always ready. A write forces reseeding
//   before the next draw. Write it only while no burst is in progress.
// Order: each word is read from the state RAM into a register, then tempered
//   into the output queue; later words follow one per cycle while it has room.
// The 624-word state lives in a RAM with one write and two read ports.
// Seeding writes the seed to word 0, then each later word through the 32x32
// multiplier and the add behind it. Regeneration passes one word per cycle
// through the mix unit. Seeding happens on the first draw after reset or a
// seed write, regeneration after seeding and every 624 words, inside a burst.
// Reset: seed returns to 5489, the output queue empties, the state is marked
// as needing a reseed. The RAM itself is not cleared.
module mersenne_twister_prng
  import mt_prng_pkg::*;
#(
  parameter int MAX_BURST = DEFAULT_MAX_BURST
) (
  input  logic        clk,
  input  logic        rst,
  mt_req_if.sink      request,
  mt_word_if.source   result,
  mt_seed_if.sink     cfg
);

  localparam int CNT_W = $clog2(MAX_BURST + 1);

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_DRAW     = 6'b000010,
    ST_SEED_MUL = 6'b000100,
    ST_SEED_ADD = 6'b001000,
    ST_TW_PRIME = 6'b010000,
    ST_TW_RUN   = 6'b100000
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   remaining;
  logic [CNT_W-1:0]   req_len;
  logic [POS_W-1:0]   pos;
  logic [WORD_W-1:0]  seed_reg;
  logic [WORD_W-1:0]  p_word;
  logic [WORD_W-1:0]  product;
  logic [WORD_W-1:0]  seed_word;
  logic [ADDR_W-1:0]  seed_idx;
  logic [POS_W-1:0]   tw_idx;
  logic               s1_valid;
  logic [ADDR_W-1:0]  s1_idx;
  logic [WORD_W-1:0]  hi_word;

  // State RAM.
  logic [WORD_W-1:0]  mem [STATE_WORDS];
  logic [WORD_W-1:0]  rd_a;
  logic [WORD_W-1:0]  rd_b;
  logic [ADDR_W-1:0]  addr_a;
  logic [ADDR_W-1:0]  addr_b;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_wa;
  logic [WORD_W-1:0]  mem_wd;

  // Output queue.
  logic               inflight;
  logic               inflight_last;
  logic [WORD_W-1:0]  q_word [2];
  logic               q_last [2];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         q_cnt;
  logic [1:0]         occ;
  logic               pop;
  logic               credit;
  logic               draw_issue;
  logic               tw_issue;

  // Handshake outputs.
  assign request.ready      = (state == ST_IDLE);
  assign cfg.ready          = 1'b1;
  assign result.valid       = (q_cnt != 2'd0);
  assign result.random_word = q_word[rd_ptr];
  assign result.burst_last  = q_last[rd_ptr];

  // Clip the requested length.
  assign req_len = (request.burst_length > BURST_W'(MAX_BURST)) ?
                   CNT_W'(MAX_BURST) : CNT_W'(request.burst_length);

  // A read may start when the queue will have room for its word.
  assign pop        = result.valid & result.ready;
  assign occ        = q_cnt + {1'b0, inflight};
  assign credit     = (occ < 2'd2) || pop;
  assign draw_issue = (state == ST_DRAW) && (pos < POS_TWIST) && credit;
  assign tw_issue   = (state == ST_TW_RUN) && (tw_idx < POS_TWIST);
  assign seed_word  = product + WORD_W'(seed_idx);

  // Read addresses.
  always_comb begin
    priority if (state == ST_TW_PRIME) begin
      addr_a = '0;
    end else if (state == ST_TW_RUN) begin
      addr_a = (tw_idx == POS_W'(STATE_WORDS - 1)) ? '0 : ADDR_W'(tw_idx + 1'b1);
    end else begin
      addr_a = ADDR_W'(pos);
    end
    addr_b = (tw_idx >= POS_W'(STATE_WORDS - TWIST_OFFSET)) ?
             ADDR_W'(tw_idx - POS_W'(STATE_WORDS - TWIST_OFFSET)) :
             ADDR_W'(tw_idx + POS_W'(TWIST_OFFSET));
  end

  // Write port: seed word, seed recurrence or regenerated word.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = seed_reg;
    priority if (state == ST_DRAW && pos == POS_SEED) begin
      mem_we = 1'b1;
    end else if (state == ST_SEED_ADD) begin
      mem_we = 1'b1;
      mem_wa = seed_idx;
      mem_wd = seed_word;
    end else if (state == ST_TW_RUN && s1_valid) begin
      mem_we = 1'b1;
      mem_wa = s1_idx;
      mem_wd = mix(hi_word, rd_a, rd_b);
    end else begin
      mem_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_a <= mem[addr_a];
    rd_b <= mem[addr_b];
  end

  // Output queue storage; a word read last cycle is tempered on the way in.
  always_ff @(posedge clk) begin
    if (inflight) begin
      q_word[wr_ptr] <= temper(rd_a);
      q_last[wr_ptr] <= inflight_last;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pos       <= POS_SEED;
      seed_reg  <= DEFAULT_SEED;
      remaining <= '0;
      inflight  <= 1'b0;
      s1_valid  <= 1'b0;
      q_cnt     <= '0;
      wr_ptr    <= 1'b0;
      rd_ptr    <= 1'b0;
    end else begin
      inflight <= draw_issue;
      if (draw_issue) begin
        inflight_last <= (remaining == CNT_W'(1));
      end
      if (inflight) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      q_cnt <= q_cnt + {1'b0, inflight} - {1'b0, pop};

      unique case (state)
        ST_IDLE: begin
          if (request.valid && req_len != '0) begin
            remaining <= req_len;
            state     <= ST_DRAW;
          end
        end
        ST_DRAW: begin
          if (pos == POS_SEED) begin
            p_word   <= seed_reg;
            seed_idx <= ADDR_W'(1);
            state    <= ST_SEED_MUL;
          end else if (pos == POS_TWIST) begin
            state <= ST_TW_PRIME;
          end else if (credit) begin
            pos       <= pos + 1'b1;
            remaining <= remaining - 1'b1;
            if (remaining == CNT_W'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        ST_SEED_MUL: begin
          product <= (p_word ^ (p_word >> 30)) * SEED_MULT;
          state   <= ST_SEED_ADD;
        end
        ST_SEED_ADD: begin
          p_word   <= seed_word;
          seed_idx <= seed_idx + 1'b1;
          if (seed_idx == ADDR_W'(STATE_WORDS - 1)) begin
            state <= ST_TW_PRIME;
          end else begin
            state <= ST_SEED_MUL;
          end
        end
        ST_TW_PRIME: begin
          tw_idx   <= '0;
          s1_valid <= 1'b0;
          state    <= ST_TW_RUN;
        end
        ST_TW_RUN: begin
          // hi_word keeps the unmodified word for the index being written.
          hi_word  <= rd_a;
          s1_valid <= tw_issue;
          s1_idx   <= ADDR_W'(tw_idx);
          if (tw_issue) begin
            tw_idx <= tw_idx + 1'b1;
          end
          if (s1_valid && s1_idx == ADDR_W'(STATE_WORDS - 1)) begin
            pos   <= '0;
            state <= ST_DRAW;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      // A seed write forces a reseed on the next draw.
      if (cfg.valid) begin
        seed_reg <= cfg.seed;
        pos      <= POS_SEED;
      end
    end
  end

endmodule

// ----- src/mt_prng_checker.sv -----
`include "mersenne_twister_prng_macros.svh"

// Port-level checks of the generator.
module mt_prng_checker
  import mt_prng_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  mt_req_if.sink    request,
  mt_word_if.source result
);

  // A stalled result word stays offered.
  `MTP_CHECK(a_result_held, clk, rst, result.valid && !result.ready |=> result.valid, "result valid dropped while stalled")

  // A stalled result word keeps its payload.
  `MTP_CHECK(a_result_stable, clk, rst, result.valid && !result.ready |=> $stable(result.random_word) && $stable(result.burst_last), "result payload changed while stalled")

  // Reset empties the output queue.
  `MTP_CHECK_ALWAYS(a_reset_empty, clk, rst |=> !result.valid, "result valid right after reset")

  // A nonempty burst closes the request side while it is read out.
  `MTP_CHECK(a_busy_after_req, clk, rst, request.valid && request.ready && request.burst_length != '0 |=> !request.ready, "request taken during a burst")

endmodule

bind mersenne_twister_prng mt_prng_checker u_mt_prng_checker (
  .clk     (clk),
  .rst     (rst),
  .request (request),
  .result  (result)
);
